/* rtl/egcd_pkg.sv */
// Package for the extended gcd unit: transfer payload types and field widths.
`default_nettype none

package egcd_pkg;

    localparam int unsigned OPND_FIELD_W  = 31;
    localparam int unsigned COEFF_FIELD_W = 32;

    typedef struct packed {
        logic [OPND_FIELD_W-1:0] first_value;
        logic [OPND_FIELD_W-1:0] second_value;
    } t_egcd_in;

    typedef struct packed {
        logic        [OPND_FIELD_W-1:0]  divisor;
        logic signed [COEFF_FIELD_W-1:0] coeff_first;
        logic signed [COEFF_FIELD_W-1:0] coeff_second;
    } t_egcd_out;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_DONE  = 4'b1000
    } t_egcd_state;

endpackage

`default_nettype wire

/* rtl/extended_gcd_unit_top.sv */
// Extended gcd unit: gcd and Bezout coefficients by iterative extended Euclid.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_data  (first_value, second_value)
//  out     | output    | o_out_valid / i_out_stall  | o_out_data (divisor, coeff_first,
//          |           |                            |             coeff_second)
//
// Each Euclid round is one check state, then OW steps of a shared
// restoring divide step, which also builds q*x1 and q*y1 by shift-and-add (MSB first).
// The round update is folded into the last divide step.
// One item at a time: o_in_stall is high from the accepting edge until the result
// transfers. The result waits in an output register while i_out_stall is high.
// Reset (synchronous, active low) returns the sequencer to idle; no clearing pass.
`default_nettype none

module extended_gcd_unit_top
    import egcd_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_egcd_in  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_egcd_out      o_out_data
);

    // operand width: DATA_WIDTH-1 bits, capped by the 31-bit field
    localparam int unsigned OW    = (DATA_WIDTH - 1 < OPND_FIELD_W) ? DATA_WIDTH - 1
                                                                    : OPND_FIELD_W;
    localparam int unsigned CW    = DATA_WIDTH;
    localparam int unsigned CNT_W = $clog2(OW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OW - 1);

    t_egcd_state      r_state, n_state;
    logic [OW-1:0]    r_rem_hi, n_rem_hi;
    logic [OW-1:0]    r_rem_lo, n_rem_lo;
    logic [OW-1:0]    r_dvd, n_dvd;
    logic [OW-1:0]    r_part, n_part;
    logic [CW-1:0]    r_cx_hi, n_cx_hi, r_cx_lo, n_cx_lo;
    logic [CW-1:0]    r_cy_hi, n_cy_hi, r_cy_lo, n_cy_lo;
    logic [CW-1:0]    r_tx, n_tx, r_ty, n_ty;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_egcd_out        r_out, n_out;

    logic [OW:0]      shifted;
    logic             ge;
    logic [OW-1:0]    diff;

    // one restoring divide step, plus shift-and-add of quotient times coefficients
    always_comb begin
        shifted = {r_part, r_dvd[OW-1]};
        ge      = shifted >= {1'b0, r_rem_lo};
        // exact whenever ge, since the difference is below the divisor
        diff    = shifted[OW-1:0] - r_rem_lo;
        n_part  = ge ? diff : shifted[OW-1:0];
        n_tx    = {r_tx[CW-2:0], 1'b0} + (ge ? r_cx_lo : '0);
        n_ty    = {r_ty[CW-2:0], 1'b0} + (ge ? r_cy_lo : '0);
    end

    always_comb begin
        n_state  = r_state;
        n_rem_hi = r_rem_hi;
        n_rem_lo = r_rem_lo;
        n_dvd    = r_dvd;
        n_cx_hi  = r_cx_hi;
        n_cx_lo  = r_cx_lo;
        n_cy_hi  = r_cy_hi;
        n_cy_lo  = r_cy_lo;
        n_cnt    = r_cnt;
        n_out    = r_out;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rem_hi = i_in_data.first_value[OW-1:0];
                    n_rem_lo = i_in_data.second_value[OW-1:0];
                    n_cx_hi  = CW'(1);
                    n_cx_lo  = '0;
                    n_cy_hi  = '0;
                    n_cy_lo  = CW'(1);
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_rem_lo == '0) begin
                    n_out.divisor      = OPND_FIELD_W'(r_rem_hi);
                    n_out.coeff_first  = COEFF_FIELD_W'(r_cx_hi);
                    n_out.coeff_second = COEFF_FIELD_W'(r_cy_hi);
                    n_state            = S_DONE;
                end else begin
                    n_dvd   = r_rem_hi;
                    n_cnt   = CNT_LAST;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_dvd = {r_dvd[OW-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    // last quotient bit: retire the round
                    n_rem_hi = r_rem_lo;
                    n_rem_lo = n_part;
                    n_cx_hi  = r_cx_lo;
                    n_cx_lo  = r_cx_hi - n_tx;
                    n_cy_hi  = r_cy_lo;
                    n_cy_lo  = r_cy_hi - n_ty;
                    n_state  = S_CHECK;
                end
            end
            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem_hi <= n_rem_hi;
        r_rem_lo <= n_rem_lo;
        r_dvd    <= n_dvd;
        r_cx_hi  <= n_cx_hi;
        r_cx_lo  <= n_cx_lo;
        r_cy_hi  <= n_cy_hi;
        r_cy_lo  <= n_cy_lo;
        r_cnt    <= n_cnt;
        r_out    <= n_out;
        if (r_state == S_CHECK) begin
            r_part <= '0;
            r_tx   <= '0;
            r_ty   <= '0;
        end else if (r_state == S_DIV) begin
            r_part <= n_part;
            r_tx   <= n_tx;
            r_ty   <= n_ty;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_out_data  = r_out;

`ifndef SYNTH
    // partial remainder always stays below the divisor
    a_part_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_part < r_rem_lo))
        else $error("partial remainder not below divisor");

    // a divide never starts or runs with a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem_lo != '0))
        else $error("divide running with zero divisor");

    // an input transfer always starts a check round
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_CHECK))
        else $error("input transfer did not start a round");

    // result held until it transfers
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(r_out)))
        else $error("result dropped while stalled");
`endif

endmodule

`default_nettype wire

/* sim/tb_extended_gcd_unit_top.sv */
// Testbench for extended_gcd_unit_top: gcd and Bezout coefficients against a predictor.
`timescale 1ns / 100ps

module tb_extended_gcd_unit_top;
    import egcd_pkg::*;

    localparam logic [OPND_FIELD_W-1:0] OPND_MAX = '1;
    localparam int RANDOM_ITEMS    = 400;
    localparam int CALM_ITEMS      = 40;
    localparam int HOLD_AFTER      = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int QUIET_LIMIT     = 10000;
    localparam int DRAIN_CYCLES    = 100;

    typedef struct {
        t_egcd_in  opnds;
        bit        typed;
        t_egcd_out want;
    } t_gcd_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_egcd_in  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_egcd_out o_out_data;

    t_egcd_out pending_bezout_q[$];
    t_gcd_row  directed_q[$];
    int        error_count  = 0;
    int        results_seen = 0;
    bit        calm_tail    = 1'b0;

    extended_gcd_unit_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Extended Euclid with 64-bit wrapping coefficients, truncated to the field widths.
    function automatic t_egcd_out bezout_of(input t_egcd_in opnds);
        logic [63:0] r_a, r_b, x_a, x_b, y_a, y_b, quot, nxt;
        t_egcd_out   res;
        r_a = 64'(opnds.first_value);
        r_b = 64'(opnds.second_value);
        x_a = 64'd1;
        x_b = 64'd0;
        y_a = 64'd0;
        y_b = 64'd1;
        while (r_b != 64'd0) begin
            quot = r_a / r_b;
            nxt  = r_a - quot * r_b;
            r_a  = r_b;
            r_b  = nxt;
            nxt  = x_a - quot * x_b;
            x_a  = x_b;
            x_b  = nxt;
            nxt  = y_a - quot * y_b;
            y_a  = y_b;
            y_b  = nxt;
        end
        res.divisor      = r_a[OPND_FIELD_W-1:0];
        res.coeff_first  = x_a[COEFF_FIELD_W-1:0];
        res.coeff_second = y_a[COEFF_FIELD_W-1:0];
        return res;
    endfunction

    function automatic t_gcd_row gcd_row(
        input logic [OPND_FIELD_W-1:0]         a,
        input logic [OPND_FIELD_W-1:0]         b,
        input bit                              typed = 1'b0,
        input logic [OPND_FIELD_W-1:0]         g     = '0,
        input logic signed [COEFF_FIELD_W-1:0] x     = '0,
        input logic signed [COEFF_FIELD_W-1:0] y     = '0
    );
        t_gcd_row row;
        row.opnds.first_value   = a;
        row.opnds.second_value  = b;
        row.typed               = typed;
        row.want.divisor        = g;
        row.want.coeff_first    = x;
        row.want.coeff_second   = y;
        return row;
    endfunction

    function automatic logic [OPND_FIELD_W-1:0] rand_opnd();
        logic [31:0] r;
        r = $urandom;
        return r[OPND_FIELD_W-1:0];
    endfunction

    function automatic t_egcd_in random_operands();
        t_egcd_in    opnds;
        logic [63:0] scale, fa, fb, nxt;
        logic [OPND_FIELD_W-1:0] tmp;
        int unsigned steps;
        case ($urandom_range(0, 7))
            0, 1, 2: begin
                opnds.first_value  = rand_opnd();
                opnds.second_value = rand_opnd();
            end
            3: begin
                // shared factor, so the gcd is a multiple of the scale
                scale = 64'($urandom_range(2, 65535));
                nxt   = scale * 64'($urandom_range(0, OPND_MAX / 32'(scale)));
                opnds.first_value  = nxt[OPND_FIELD_W-1:0];
                nxt   = scale * 64'($urandom_range(0, OPND_MAX / 32'(scale)));
                opnds.second_value = nxt[OPND_FIELD_W-1:0];
            end
            4: begin
                // consecutive Fibonacci numbers: the most rounds for their size
                steps = $urandom_range(20, 45);
                fa = 64'd1;
                fb = 64'd0;
                repeat (steps) begin
                    nxt = fa + fb;
                    fb  = fa;
                    fa  = nxt;
                end
                opnds.first_value  = fa[OPND_FIELD_W-1:0];
                opnds.second_value = fb[OPND_FIELD_W-1:0];
            end
            5: begin
                opnds.first_value  = OPND_FIELD_W'($urandom_range(0, 300));
                opnds.second_value = OPND_FIELD_W'($urandom_range(0, 300));
            end
            6: begin
                opnds.first_value = rand_opnd();
                case ($urandom_range(0, 2))
                    0: opnds.second_value = '0;
                    1: opnds.second_value = opnds.first_value;
                    default: begin
                        opnds.second_value = opnds.first_value;
                        opnds.first_value  = '0;
                    end
                endcase
            end
            default: begin
                opnds.first_value  = OPND_MAX - OPND_FIELD_W'($urandom_range(0, 3));
                opnds.second_value = rand_opnd();
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            tmp                = opnds.first_value;
            opnds.first_value  = opnds.second_value;
            opnds.second_value = tmp;
        end
        return opnds;
    endfunction

    // Returns at the edge where the transfer happens.
    task automatic offer_operands(input t_egcd_in opnds);
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= opnds;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    initial begin : stimulus
        t_egcd_in opnds;
        directed_q.push_back(gcd_row('0, '0, 1'b1, '0, 32'sd1, 32'sd0));
        directed_q.push_back(gcd_row(OPND_MAX, '0, 1'b1, OPND_MAX, 32'sd1, 32'sd0));
        directed_q.push_back(gcd_row(31'd1, '0, 1'b1, 31'd1, 32'sd1, 32'sd0));
        directed_q.push_back(gcd_row(31'h2AAA_AAAA, '0, 1'b1, 31'h2AAA_AAAA, 32'sd1, 32'sd0));
        directed_q.push_back(gcd_row('0, OPND_MAX, 1'b1, OPND_MAX, 32'sd0, 32'sd1));
        directed_q.push_back(gcd_row(OPND_MAX, OPND_MAX, 1'b1, OPND_MAX, 32'sd0, 32'sd1));
        directed_q.push_back(gcd_row('0, 31'd1));
        directed_q.push_back(gcd_row(OPND_MAX, 31'd1));
        directed_q.push_back(gcd_row(31'd1, OPND_MAX));
        directed_q.push_back(gcd_row(OPND_MAX, OPND_MAX - 31'd1));
        directed_q.push_back(gcd_row(OPND_MAX - 31'd1, OPND_MAX));
        directed_q.push_back(gcd_row(31'd1836311903, 31'd1134903170));
        directed_q.push_back(gcd_row(31'd1134903170, 31'd1836311903));
        directed_q.push_back(gcd_row(31'd12, 31'd18));
        directed_q.push_back(gcd_row(31'd18, 31'd12));
        directed_q.push_back(gcd_row(31'd240, 31'd46));
        directed_q.push_back(gcd_row(31'h4000_0000, 31'h2000_0000));
        directed_q.push_back(gcd_row(31'h4000_0000, 31'h3FFF_FFFF));
        directed_q.push_back(gcd_row(31'h5555_5555, 31'h2AAA_AAAA));
        directed_q.push_back(gcd_row(OPND_MAX, 31'd2147483629));
        directed_q.push_back(gcd_row(31'd1000000000, 31'd999999999));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_q[i]) begin
            offer_operands(directed_q[i].opnds);
            pending_bezout_q.push_back(directed_q[i].typed ? directed_q[i].want
                                                           : bezout_of(directed_q[i].opnds));
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n >= RANDOM_ITEMS - CALM_ITEMS)
                calm_tail = 1'b1;
            opnds = random_operands();
            offer_operands(opnds);
            pending_bezout_q.push_back(bezout_of(opnds));
        end
        i_in_valid <= 1'b0;

        while (pending_bezout_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_bezout_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Output side: random stall bursts, plus one long hold-off so the input backs up.
    initial begin : result_sink
        bit held_once;
        held_once = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_once && results_seen >= HOLD_AFTER) begin
                held_once = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_egcd_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_bezout_q.size() == 0) begin
                $error("unexpected result transfer: divisor %0d", o_out_data.divisor);
                error_count++;
            end else begin
                want = pending_bezout_q.pop_front();
                if (o_out_data.divisor !== want.divisor) begin
                    $error("divisor: expected %0d, got %0d", want.divisor, o_out_data.divisor);
                    error_count++;
                end
                if (o_out_data.coeff_first !== want.coeff_first) begin
                    $error("coeff_first: expected %0d, got %0d",
                           want.coeff_first, o_out_data.coeff_first);
                    error_count++;
                end
                if (o_out_data.coeff_second !== want.coeff_second) begin
                    $error("coeff_second: expected %0d, got %0d",
                           want.coeff_second, o_out_data.coeff_second);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/egcd_pkg.sv
rtl/extended_gcd_unit_top.sv
sim/tb_extended_gcd_unit_top.sv
